>>> rtl/core/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// shared types and constants of the limited insertion sorter
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int SCORE_W = 32;
  localparam int TAG_W   = 16;

  // register map
  localparam logic [1:0] ADDR_SORT_LIMIT = 2'd0;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [TAG_W-1:0]          tag_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } lis_state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic wr;    // a word is stored this cycle
    logic ins;   // the stored word qualifies and is inserted into the prefix
    logic emit;  // the row shifts toward cell zero
  } lis_ctl_t;

endpackage

>>> rtl/core/lis_cell.sv
// ----------------------------------------------------------------------------
// lis_cell
// one storage slot of the sorting row: compare, keep, take a neighbor or load
// ----------------------------------------------------------------------------
module lis_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  lis_pkg::lis_ctl_t ctl,
  input  logic [IDX_W-1:0]  pos,
  input  logic [IDX_W-1:0]  ins_end,
  input  lis_pkg::score_t   new_score,
  input  lis_pkg::tag_t     new_tag,
  input  lis_pkg::score_t   disp_score,
  input  lis_pkg::tag_t     disp_tag,
  input  lis_pkg::score_t   left_score,
  input  lis_pkg::tag_t     left_tag,
  input  logic              left_lt,
  input  lis_pkg::score_t   right_score,
  input  lis_pkg::tag_t     right_tag,
  output logic              lt,
  output lis_pkg::score_t   score_q,
  output lis_pkg::tag_t     tag_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  lis_pkg::score_t score_r, score_nxt;
  lis_pkg::tag_t   tag_r, tag_nxt;
  logic            in_prefix;
  logic            at_pos;

  assign lt        = score_r < new_score;
  assign in_prefix = ctl.ins && (MY_IDX <= ins_end);
  assign at_pos    = ctl.wr && (pos == MY_IDX);

  always_comb begin
    score_nxt = score_r;
    tag_nxt   = tag_r;
    priority if (ctl.emit) begin
      score_nxt = right_score;
      tag_nxt   = right_tag;
    end else if (in_prefix) begin
      priority if (left_lt) begin
        score_nxt = left_score;
        tag_nxt   = left_tag;
      end else begin
        if ((MY_IDX == ins_end) || lt) begin
          score_nxt = new_score;
          tag_nxt   = new_tag;
        end
      end
    end else begin
      if (at_pos) begin
        if (ctl.ins) begin
          score_nxt = disp_score;
          tag_nxt   = disp_tag;
        end else begin
          score_nxt = new_score;
          tag_nxt   = new_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    tag_r   <= tag_nxt;
  end

  assign score_q = score_r;
  assign tag_q   = tag_r;

endmodule

>>> rtl/core/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// list sequencer: fill count, prefix end, overflow and emission countdown
// ----------------------------------------------------------------------------
module lis_ctrl #(
  parameter int MAX_ITEMS = 64,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_item,
  input  lis_pkg::score_t   item_score,
  input  lis_pkg::score_t   sort_limit,
  output logic              busy,
  output lis_pkg::lis_ctl_t ctl,
  output logic [IDX_W-1:0]  pos,
  output logic [IDX_W-1:0]  ins_end,
  output logic              out_valid,
  output logic              out_last,
  output logic              out_overflowed
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);

  lis_pkg::lis_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    prefix_end_r, prefix_end_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    emit_left_r, emit_left_nxt;
  logic                emit_ovf_r, emit_ovf_nxt;
  logic                accept;
  logic                room;
  logic                qualify;

  assign accept  = start && (state_r == lis_pkg::ST_IDLE);
  assign room    = count_r < CAP;
  assign pos     = count_r[IDX_W-1:0];
  assign ins_end = prefix_end_r + IDX_W'(1);
  assign qualify = room && (pos != '0) && (item_score >= sort_limit);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lis_pkg::ST_IDLE: if (accept && last_item) state_nxt = lis_pkg::ST_EMIT;
      lis_pkg::ST_EMIT: if (emit_left_r == CNT_W'(1)) state_nxt = lis_pkg::ST_IDLE;
      default:          state_nxt = lis_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy           = 1'b0;
    out_valid      = 1'b0;
    ctl            = '0;
    unique case (state_r)
      lis_pkg::ST_IDLE: begin
        ctl.wr  = accept && room;
        ctl.ins = accept && qualify;
      end
      lis_pkg::ST_EMIT: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        ctl.emit  = 1'b1;
      end
      default: ;
    endcase
    out_last       = emit_left_r == CNT_W'(1);
    out_overflowed = emit_ovf_r;
  end

  // list bookkeeping
  always_comb begin
    count_nxt      = count_r;
    prefix_end_nxt = prefix_end_r;
    ovf_nxt        = ovf_r;
    emit_left_nxt  = emit_left_r;
    emit_ovf_nxt   = emit_ovf_r;
    if (state_r == lis_pkg::ST_EMIT) begin
      emit_left_nxt = emit_left_r - CNT_W'(1);
    end else if (accept) begin
      if (last_item) begin
        emit_left_nxt  = room ? count_r + CNT_W'(1) : count_r;
        emit_ovf_nxt   = ovf_r || !room;
        count_nxt      = '0;
        prefix_end_nxt = '0;
        ovf_nxt        = 1'b0;
      end else begin
        if (room) count_nxt = count_r + CNT_W'(1);
        else      ovf_nxt   = 1'b1;
        if (qualify) prefix_end_nxt = ins_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lis_pkg::ST_IDLE;
      count_r      <= '0;
      prefix_end_r <= '0;
      ovf_r        <= 1'b0;
      emit_left_r  <= '0;
      emit_ovf_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      prefix_end_r <= prefix_end_nxt;
      ovf_r        <= ovf_nxt;
      emit_left_r  <= emit_left_nxt;
      emit_ovf_r   <= emit_ovf_nxt;
    end
  end

endmodule

>>> rtl/core/limited_insertion_sorter.sv
// ----------------------------------------------------------------------------
// limited_insertion_sorter
// partial descending insertion sort of a (score, tag) list above a limit
// ----------------------------------------------------------------------------
// An input word is taken whenever busy is low: a row of MAX_ITEMS cells
// compares the new score in parallel and shifts the sorted prefix in that
// same cycle. The word marked last_item starts emission: busy goes high and
// the stored list leaves from cell zero one word per cycle on out_valid,
// after which busy drops. Results cannot be stalled, the receiver must take
// every strobed word. Words past MAX_ITEMS are dropped and out_overflowed
// is set on the list. sort_limit is written through the register port; the
// user must do so only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module limited_insertion_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_item_score,
  input  logic [15:0]           in_item_tag,
  input  logic                  in_last_item,
  output logic                  out_valid,
  output logic signed [31:0]    out_score,
  output logic [15:0]           out_tag,
  output logic                  out_last,
  output logic                  out_overflowed,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  lis_pkg::score_t   sort_limit_r;
  lis_pkg::lis_ctl_t ctl;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  ins_end;
  lis_pkg::score_t   cell_score [MAX_ITEMS];
  lis_pkg::tag_t     cell_tag   [MAX_ITEMS];
  logic              cell_lt    [MAX_ITEMS];
  lis_pkg::score_t   disp_score;
  lis_pkg::tag_t     disp_tag;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == lis_pkg::ADDR_SORT_LIMIT) ? sort_limit_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_limit_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      sort_limit_r <= pwdata;
    end
  end

  lis_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .last_item      (in_last_item),
    .item_score     (in_item_score),
    .sort_limit     (sort_limit_r),
    .busy           (busy),
    .ctl            (ctl),
    .pos            (pos),
    .ins_end        (ins_end),
    .out_valid      (out_valid),
    .out_last       (out_last),
    .out_overflowed (out_overflowed)
  );

  // word displaced from the slot just past the prefix
  assign disp_score = cell_score[ins_end];
  assign disp_tag   = cell_tag[ins_end];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    lis_pkg::score_t l_score, r_score;
    lis_pkg::tag_t   l_tag, r_tag;
    logic            l_lt;

    if (i == 0) begin : g_first
      assign l_score = cell_score[0];
      assign l_tag   = cell_tag[0];
      assign l_lt    = 1'b0;
    end else begin : g_inner
      assign l_score = cell_score[i-1];
      assign l_tag   = cell_tag[i-1];
      assign l_lt    = cell_lt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign r_score = cell_score[i];
      assign r_tag   = cell_tag[i];
    end else begin : g_mid
      assign r_score = cell_score[i+1];
      assign r_tag   = cell_tag[i+1];
    end

    lis_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .pos         (pos),
      .ins_end     (ins_end),
      .new_score   (in_item_score),
      .new_tag     (in_item_tag),
      .disp_score  (disp_score),
      .disp_tag    (disp_tag),
      .left_score  (l_score),
      .left_tag    (l_tag),
      .left_lt     (l_lt),
      .right_score (r_score),
      .right_tag   (r_tag),
      .lt          (cell_lt[i]),
      .score_q     (cell_score[i]),
      .tag_q       (cell_tag[i])
    );
  end

  assign out_score = cell_score[0];
  assign out_tag   = cell_tag[0];

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the limited insertion sorter
// ----------------------------------------------------------------------------
// Lists of (score, tag) words are fed through the command port while the
// sort limit is stepped through its extremes and random values on the
// register port. A predictor keeps its own copy of the row, the prefix end,
// the word count and the drop flag. It queues the whole expected list
// whenever the word marked last is taken. Every strobed result word is
// checked field by field against the oldest queued word. Directed lists come
// first: single words, ties, words below the limit and field extremes. Random
// lists follow, some of them filling the row or running past it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = 64;
  localparam lis_pkg::score_t SCORE_MAX = 32'sh7fff_ffff;
  localparam lis_pkg::score_t SCORE_MIN = 32'sh8000_0000;

  typedef struct {
    lis_pkg::score_t score;
    lis_pkg::tag_t   tag;
    logic            last;
  } list_word_t;

  typedef struct {
    lis_pkg::score_t score;
    lis_pkg::tag_t   tag;
    logic            last;
    logic            ovf;
  } sorted_word_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  lis_pkg::score_t in_item_score = '0;
  lis_pkg::tag_t   in_item_tag = '0;
  logic            in_last_item = 1'b0;
  logic            out_valid;
  lis_pkg::score_t out_score;
  lis_pkg::tag_t   out_tag;
  logic            out_last;
  logic            out_overflowed;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [1:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  list_word_t   pending_words[$];
  sorted_word_t sorted_due[$];
  int           mismatches = 0;
  bit           calm = 1'b0;

  // predictor state
  lis_pkg::score_t limit_q = '0;
  lis_pkg::score_t row_score[DEPTH];
  lis_pkg::tag_t   row_tag[DEPTH];
  int unsigned     held = 0;
  int unsigned     prefix_top = 0;
  bit              dropped = 1'b0;

  limited_insertion_sorter #(.MAX_ITEMS(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item_score(in_item_score), .in_item_tag(in_item_tag),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_score(out_score), .out_tag(out_tag),
    .out_last(out_last), .out_overflowed(out_overflowed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic sort_word(input lis_pkg::score_t s, input lis_pkg::tag_t t,
                           input logic last);
    sorted_word_t r;
    int unsigned q;
    if (held < DEPTH) begin
      row_score[held] = s;
      row_tag[held] = t;
      if (held == 0) begin
        prefix_top = 0;
      end else if (s >= limit_q) begin
        prefix_top = prefix_top + 1;
        row_score[held] = row_score[prefix_top];
        row_tag[held] = row_tag[prefix_top];
        q = prefix_top;
        while (q > 0 && row_score[q-1] < s) begin
          row_score[q] = row_score[q-1];
          row_tag[q] = row_tag[q-1];
          q--;
        end
        row_score[q] = s;
        row_tag[q] = t;
      end
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < held; i++) begin
        r.score = row_score[i];
        r.tag = row_tag[i];
        r.last = (i + 1 == held);
        r.ovf = dropped;
        sorted_due.push_back(r);
      end
      held = 0;
      prefix_top = 0;
      dropped = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    list_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) sort_word(in_item_score, in_item_tag, in_last_item);
      if (start && busy) begin
        // hold the word until it is taken
      end else if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        w = pending_words.pop_front();
        start <= 1'b1;
        in_item_score <= w.score;
        in_item_tag <= w.tag;
        in_last_item <= w.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sorted_word_t e;
    if (rst_n && out_valid) begin
      if (sorted_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word score=%0d tag=%h last=%b ovf=%b",
                                out_score, out_tag, out_last, out_overflowed));
      end else begin
        e = sorted_due.pop_front();
        if (out_score !== e.score || out_tag !== e.tag || out_last !== e.last ||
            out_overflowed !== e.ovf)
          flag_mismatch($sformatf(
            "expected score=%0d tag=%h last=%b ovf=%b, got score=%0d tag=%h last=%b ovf=%b",
            e.score, e.tag, e.last, e.ovf, out_score, out_tag, out_last, out_overflowed));
      end
    end
  end

  task automatic push_word(input lis_pkg::score_t s, input lis_pkg::tag_t t,
                           input logic last);
    list_word_t w;
    w.score = s;
    w.tag = t;
    w.last = last;
    pending_words.push_back(w);
  endtask

  function automatic lis_pkg::score_t pick_score();
    case ($urandom_range(7))
      0: return SCORE_MAX;
      1: return SCORE_MIN;
      2: return limit_q;
      3: return limit_q - 1;
      4: return limit_q + 1;
      5: return lis_pkg::score_t'($urandom_range(8)) - 4;
      default: return lis_pkg::score_t'($urandom);
    endcase
  endfunction

  task automatic add_list(input int len);
    for (int i = 0; i < len; i++)
      push_word(pick_score(), lis_pkg::tag_t'($urandom), i == len - 1);
  endtask

  task automatic add_lists(input int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      if (len > budget) len = budget;
      add_list(len);
      budget -= len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || sorted_due.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input lis_pkg::score_t v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lis_pkg::ADDR_SORT_LIMIT;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    limit_q = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== limit_q)
      flag_mismatch($sformatf("sort_limit read expected %h, got %h", limit_q, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lists at the reset limit of zero
    push_word(SCORE_MAX, 16'hffff, 1'b1);
    push_word(SCORE_MIN, 16'h0000, 1'b1);
    push_word(0, 16'h0001, 1'b0);
    push_word(-1, 16'h0002, 1'b0);
    push_word(5, 16'h0003, 1'b0);
    push_word(5, 16'h0004, 1'b0);
    push_word(3, 16'h0005, 1'b0);
    push_word(SCORE_MIN, 16'h0006, 1'b0);
    push_word(SCORE_MAX, 16'h0007, 1'b0);
    push_word(0, 16'h0008, 1'b1);
    push_word(-5, 16'haaaa, 1'b0);
    push_word(7, 16'h5555, 1'b0);
    push_word(7, 16'h1234, 1'b0);
    push_word(-1, 16'h8000, 1'b0);
    push_word(SCORE_MAX, 16'h7fff, 1'b1);
    push_word(-1, 16'h0011, 1'b0);
    push_word(-2, 16'h0012, 1'b0);
    push_word(-3, 16'h0013, 1'b1);
    wait_idle();

    // everything sorts, one full row
    write_limit(SCORE_MIN);
    add_list(DEPTH);
    add_lists(10);
    wait_idle();

    // only the top score sorts
    write_limit(SCORE_MAX);
    add_lists(50);
    wait_idle();

    // limit near zero, no gaps, overflow with the mark on a dropped word
    write_limit(lis_pkg::score_t'($urandom_range(6)) - 3);
    calm = 1'b1;
    add_list(DEPTH + 2);
    add_lists(30);
    wait_idle();
    calm = 1'b0;

    write_limit(lis_pkg::score_t'($urandom));
    add_lists(50);
    wait_idle();

    write_limit(0);
    add_list(DEPTH + 6);
    add_lists(20);
    wait_idle();

    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lis_pkg.sv
rtl/core/lis_cell.sv
rtl/core/lis_ctrl.sv
rtl/core/limited_insertion_sorter.sv
sim/tb_top.sv
